// ===== src/imu_frame_checksum_decoder_assert.svh =====
// Assertion macros shared by the frame decoder RTL
`ifndef IMU_FRAME_CHECKSUM_DECODER_ASSERT_SVH
`define IMU_FRAME_CHECKSUM_DECODER_ASSERT_SVH

// Same-cycle implication, masked during reset
`define IFCD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define IFCD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ifcd_pkg.sv =====
// Shared types and constants of the IMU frame decoder
`timescale 1ns / 1ps
`default_nettype none
package ifcd_pkg;

    localparam int FRAME_LEN   = 11;
    localparam int FILL_W      = $clog2(FRAME_LEN + 1);
    localparam int SCALE_SHIFT = 15;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_MAG   = 8'h54;

    localparam logic [15:0] RESET_ACCEL = 16'd16;
    localparam logic [15:0] RESET_RATE  = 16'd2000;
    localparam logic [15:0] RESET_ANGLE = 16'd180;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACCEL = 2'd0;
    localparam logic [1:0] CFG_RATE  = 2'd1;
    localparam logic [1:0] CFG_ANGLE = 2'd2;

    typedef enum logic [2:0] {
        KIND_ACCEL = 3'd0,
        KIND_RATE  = 3'd1,
        KIND_ANGLE = 3'd2,
        KIND_MAG   = 3'd3,
        KIND_OTHER = 3'd4
    } t_kind;

    // One classified frame waiting for the arithmetic back end
    typedef struct packed {
        logic               frame_ok;
        t_kind              kind;
        logic               mag;
        logic               zero;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic [15:0]        scale;
    } t_entry;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

// ===== src/ifcd_front.sv =====
// Front end: byte window, header detect, checksum and type decode
`timescale 1ns / 1ps
`default_nettype none
module ifcd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire logic          i_q_full,
    output logic               o_push,
    output ifcd_pkg::t_entry   o_entry
);
    import ifcd_pkg::*;

    logic [7:0]        r_win [FRAME_LEN];
    logic [7:0]        w_nx  [FRAME_LEN];
    logic [FILL_W-1:0] r_fill;
    logic [15:0]       r_accel_scale;
    logic [15:0]       r_rate_scale;
    logic [15:0]       r_angle_scale;
    logic              w_take;
    logic              w_full;
    logic [7:0]        w_sum;

    // Accept a word whenever the queue has room
    assign o_rx_ready = !i_q_full;
    assign w_take     = i_rx_valid && o_rx_ready;

    // Window as it stands after the incoming word is shifted in
    always_comb begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            w_nx[i] = r_win[i + 1];
        end
        w_nx[FRAME_LEN - 1] = i_rx_byte;
    end

    assign w_full = (r_fill >= FILL_W'(FRAME_LEN - 1));

    // Wrapping sum of all bytes but the checksum
    always_comb begin
        w_sum = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            w_sum = w_sum + w_nx[i];
        end
    end

    // Classify the frame and pick its scale
    always_comb begin
        o_entry.frame_ok = (w_sum == w_nx[FRAME_LEN - 1]);
        o_entry.raw_x    = {w_nx[3], w_nx[2]};
        o_entry.raw_y    = {w_nx[5], w_nx[4]};
        o_entry.raw_z    = {w_nx[7], w_nx[6]};
        o_entry.mag      = 1'b0;
        o_entry.scale    = 16'd0;
        unique case (w_nx[1])
            TYPE_ACC: begin
                o_entry.kind  = KIND_ACCEL;
                o_entry.scale = r_accel_scale;
            end
            TYPE_RATE: begin
                o_entry.kind  = KIND_RATE;
                o_entry.scale = r_rate_scale;
            end
            TYPE_ANGLE: begin
                o_entry.kind  = KIND_ANGLE;
                o_entry.scale = r_angle_scale;
            end
            TYPE_MAG: begin
                o_entry.kind = KIND_MAG;
                o_entry.mag  = 1'b1;
            end
            default: begin
                o_entry.kind = KIND_OTHER;
            end
        endcase
        o_entry.zero = !o_entry.frame_ok || (o_entry.kind == KIND_OTHER);
    end

    assign o_push = w_take && w_full && (w_nx[0] == HDR_BYTE);

    // Advance the window on every accepted word
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                r_win[i] <= w_nx[i];
            end
        end
    end

    // Fill count saturates once the window holds a whole frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_take && (r_fill != FILL_W'(FRAME_LEN))) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // Scale registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_scale <= RESET_ACCEL;
            r_rate_scale  <= RESET_RATE;
            r_angle_scale <= RESET_ANGLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACCEL: r_accel_scale <= i_cfg_wdata;
                CFG_RATE:  r_rate_scale  <= i_cfg_wdata;
                CFG_ANGLE: r_angle_scale <= i_cfg_wdata;
                default:   ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/ifcd_queue.sv =====
// Two-entry queue between front end and arithmetic back end
`timescale 1ns / 1ps
`default_nettype none
module ifcd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ifcd_pkg::t_entry i_entry,
    input  wire logic          i_pop,
    output ifcd_pkg::t_entry   o_head,
    output ifcd_pkg::t_q_stat  o_stat
);
    import ifcd_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/ifcd_back.sv =====
// Back end: axis scaling pipeline and output register
`timescale 1ns / 1ps
`default_nettype none
module ifcd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ifcd_pkg::t_entry  i_head,
    input  wire ifcd_pkg::t_q_stat i_q_stat,
    output logic               o_pop,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output logic               o_frame_ok,
    output logic [2:0]         o_kind,
    output logic signed [16:0] o_axis_x,
    output logic signed [16:0] o_axis_y,
    output logic signed [16:0] o_axis_z
);
    import ifcd_pkg::*;

    // Divide by full scale, truncating toward zero
    function automatic logic signed [16:0] f_div_full(input logic signed [32:0] p);
        logic signed [32:0] adj;
        adj = p + (p[32] ? 33'sd32767 : 33'sd0);
        return adj[SCALE_SHIFT + 16:SCALE_SHIFT];
    endfunction

    // Pick the axis result for one lane
    function automatic logic signed [16:0] f_axis(input logic zero, input logic mag,
                                                  input logic signed [15:0] raw,
                                                  input logic signed [32:0] prod);
        logic signed [16:0] res;
        if (zero) begin
            res = 17'sd0;
        end else if (mag) begin
            res = 17'(raw);
        end else begin
            res = f_div_full(prod);
        end
        return res;
    endfunction

    logic               r_s1_valid;
    logic               r_s1_ok;
    t_kind              r_s1_kind;
    logic               r_s1_mag;
    logic               r_s1_zero;
    logic signed [15:0] r_s1_raw_x;
    logic signed [15:0] r_s1_raw_y;
    logic signed [15:0] r_s1_raw_z;
    logic signed [32:0] r_s1_prod_x;
    logic signed [32:0] r_s1_prod_y;
    logic signed [32:0] r_s1_prod_z;
    logic signed [16:0] w_scale;
    logic               w_out_take;
    logic               w_s1_free;

    assign w_out_take = !o_res_valid || i_res_ready;
    assign w_s1_free  = !r_s1_valid || w_out_take;
    assign o_pop      = !i_q_stat.empty && w_s1_free;
    assign w_scale    = signed'({1'b0, i_head.scale});

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_ok     <= i_head.frame_ok;
            r_s1_kind   <= i_head.kind;
            r_s1_mag    <= i_head.mag;
            r_s1_zero   <= i_head.zero;
            r_s1_raw_x  <= i_head.raw_x;
            r_s1_raw_y  <= i_head.raw_y;
            r_s1_raw_z  <= i_head.raw_z;
            r_s1_prod_x <= 33'(i_head.raw_x) * 33'(w_scale);
            r_s1_prod_y <= 33'(i_head.raw_y) * 33'(w_scale);
            r_s1_prod_z <= 33'(i_head.raw_z) * 33'(w_scale);
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (w_out_take) begin
            o_res_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take && r_s1_valid) begin
            o_frame_ok <= r_s1_ok;
            o_kind     <= r_s1_kind;
            o_axis_x   <= f_axis(r_s1_zero, r_s1_mag, r_s1_raw_x, r_s1_prod_x);
            o_axis_y   <= f_axis(r_s1_zero, r_s1_mag, r_s1_raw_y, r_s1_prod_y);
            o_axis_z   <= f_axis(r_s1_zero, r_s1_mag, r_s1_raw_z, r_s1_prod_z);
        end
    end

endmodule
`default_nettype wire

// ===== src/imu_frame_checksum_decoder.sv =====
// Top level of the IMU serial frame checksum decoder
// Usage:
//   Input channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one serial
//   byte per word. The last 11 bytes form a sliding window; each time the
//   oldest byte is the 0x55 header, one result word is produced.
//   Output channel (o_res_valid / i_res_ready) carries frame_ok, kind and
//   the three scaled axes. The user must write the scale registers through
//   i_cfg_we, i_cfg_idx and i_cfg_wdata only while the block is idle; the
//   block itself does not enforce this. Once the completing byte is
//   accepted, the result is registered in the queue, the multiply stage
//   and the output register. Throughput: one byte per cycle while the
//   queue has room; a two-entry queue between the byte window and the
//   multiply pipeline keeps input flowing while a result awaits the receiver.
//   Stall: when the receiver holds i_res_ready low the output word holds,
//   the pipeline and queue fill, and o_rx_ready drops once the queue is full.
//   Reset: synchronous, active low; clears window fill, queue and valid
//   flags and restores scales to 16, 2000 and 180.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_frame_checksum_decoder_assert.svh"
module imu_frame_checksum_decoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_wdata,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output logic               o_frame_ok,
    output logic [2:0]         o_kind,
    output logic signed [16:0] o_axis_x,
    output logic signed [16:0] o_axis_y,
    output logic signed [16:0] o_axis_z
);
    import ifcd_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_entry  w_entry;
    t_entry  w_head;
    t_q_stat w_qs;

    ifcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (w_qs.full),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    ifcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qs)
    );

    ifcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_stat    (w_qs),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_frame_ok  (o_frame_ok),
        .o_kind      (o_kind),
        .o_axis_x    (o_axis_x),
        .o_axis_y    (o_axis_y),
        .o_axis_z    (o_axis_z)
    );

    `IFCD_ASSERT_IMP(a_q_stat, i_clk, i_rst_n, 1'b1, !(w_qs.full && w_qs.empty), "queue full and empty")
    `IFCD_ASSERT_IMP(a_push_src, i_clk, i_rst_n, w_push, i_rx_valid && o_rx_ready, "push without accepted byte")
    `IFCD_ASSERT_NXT(a_push_fill, i_clk, i_rst_n, w_push && !w_pop, !w_qs.empty, "pushed entry lost")
    `IFCD_ASSERT_IMP(a_other_zero, i_clk, i_rst_n, o_res_valid && (o_kind == KIND_OTHER), (o_axis_x == 17'sd0) && (o_axis_y == 17'sd0) && (o_axis_z == 17'sd0), "unknown kind with nonzero axis")

endmodule
`default_nettype wire
